// ===== design/pfc_pkg.sv =====
package pfc_pkg;

  localparam int unsigned GridSide   = 6;
  localparam int unsigned NumCells   = GridSide * GridSide;
  localparam int unsigned NumLetters = 26;
  localparam int unsigned DigitBase  = 48;
  localparam logic [5:0]  FillSymbol = 6'd25;
  localparam int unsigned SymW       = 6;
  localparam int unsigned CoordW     = 3;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_KEY     = 2'd1,
    KIND_FINISH  = 2'd2,
    KIND_DIGRAPH = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_FILL = 2'd1,
    ST_ADDR = 2'd2
  } state_e;

  typedef enum logic [0:0] {
    REG_DECRYPT = 1'b0
  } reg_idx_e;

  // control from the sequencer to the key square
  typedef struct packed {
    logic            clear;
    logic            place_en;
    logic [SymW-1:0] place_sym;
    logic            sym_rd_en;
    logic [SymW-1:0] sym_a;
    logic [SymW-1:0] sym_b;
    logic            cell_rd_en;
    logic [SymW-1:0] cell_a;
    logic [SymW-1:0] cell_b;
  } sq_ctrl_t;

  // registered read data from the key square
  typedef struct packed {
    logic [SymW-1:0] pos_a;
    logic [SymW-1:0] pos_b;
    logic [SymW-1:0] cell_a;
    logic [SymW-1:0] cell_b;
  } sq_data_t;

  function automatic logic [SymW-1:0] to_symbol(input logic [7:0] c);
    logic [SymW-1:0] s;
    if (c >= 8'h41 && c <= 8'h5a) begin
      s = SymW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s = SymW'(c - 8'h61);
    end else if (c >= 8'(DigitBase) && c <= 8'(DigitBase + 9)) begin
      s = SymW'(c - 8'(DigitBase) + 8'(NumLetters));
    end else begin
      s = FillSymbol;
    end
    return s;
  endfunction

  function automatic logic [7:0] to_ascii(input logic [SymW-1:0] s);
    logic [7:0] c;
    if (s < SymW'(NumLetters)) begin
      c = 8'h61 + 8'(s);
    end else begin
      c = 8'(DigitBase) + 8'(s - SymW'(NumLetters));
    end
    return c;
  endfunction

endpackage

// ===== design/pfc_square.sv =====
module pfc_square (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfc_pkg::sq_ctrl_t ctrl_i,
  output pfc_pkg::sq_data_t data_o
);

  logic [pfc_pkg::SymW-1:0] cell_mem [pfc_pkg::NumCells];
  logic [pfc_pkg::SymW-1:0] sym_mem  [pfc_pkg::NumCells];

  logic [pfc_pkg::NumCells-1:0] used_q, used_d;
  logic [pfc_pkg::SymW-1:0]     fill_q, fill_d;
  logic                         place_ok;

  assign place_ok = ctrl_i.place_en && !used_q[ctrl_i.place_sym] &&
                    (fill_q < pfc_pkg::SymW'(pfc_pkg::NumCells));

  always_comb begin
    used_d = used_q;
    fill_d = fill_q;
    if (ctrl_i.clear) begin
      used_d = '0;
      fill_d = '0;
    end else if (place_ok) begin
      used_d[ctrl_i.place_sym] = 1'b1;
      fill_d = fill_q + pfc_pkg::SymW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      fill_q <= '0;
    end else begin
      used_q <= used_d;
      fill_q <= fill_d;
    end
  end

  // placement write port
  always_ff @(posedge clk_i) begin
    if (place_ok && !ctrl_i.clear) begin
      cell_mem[fill_q]          <= ctrl_i.place_sym;
      sym_mem[ctrl_i.place_sym] <= fill_q;
    end
  end

  // two registered read ports per table
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sym_rd_en) begin
      data_o.pos_a <= sym_mem[ctrl_i.sym_a];
      data_o.pos_b <= sym_mem[ctrl_i.sym_b];
    end
    if (ctrl_i.cell_rd_en) begin
      data_o.cell_a <= cell_mem[ctrl_i.cell_a];
      data_o.cell_b <= cell_mem[ctrl_i.cell_b];
    end
  end

endmodule

// ===== design/pfc_rule.sv =====
module pfc_rule (
  input  logic [pfc_pkg::SymW-1:0] pos_a_i,
  input  logic [pfc_pkg::SymW-1:0] pos_b_i,
  input  logic                     decrypt_i,
  output logic [pfc_pkg::SymW-1:0] cell_a_o,
  output logic [pfc_pkg::SymW-1:0] cell_b_o
);

  localparam logic [pfc_pkg::CoordW-1:0] LastCoord = pfc_pkg::CoordW'(pfc_pkg::GridSide - 1);

  function automatic logic [pfc_pkg::CoordW-1:0] row_of(input logic [pfc_pkg::SymW-1:0] p);
    logic [pfc_pkg::CoordW-1:0] r;
    r = '0;
    for (int k = 1; k < pfc_pkg::GridSide; k++) begin
      if (p >= pfc_pkg::SymW'(k * pfc_pkg::GridSide)) begin
        r = pfc_pkg::CoordW'(k);
      end
    end
    return r;
  endfunction

  function automatic logic [pfc_pkg::CoordW-1:0] col_of(input logic [pfc_pkg::SymW-1:0] p,
                                                        input logic [pfc_pkg::CoordW-1:0] r);
    logic [pfc_pkg::SymW-1:0] base;
    base = pfc_pkg::SymW'(r) * pfc_pkg::SymW'(pfc_pkg::GridSide);
    return pfc_pkg::CoordW'(p - base);
  endfunction

  function automatic logic [pfc_pkg::CoordW-1:0] inc(input logic [pfc_pkg::CoordW-1:0] x);
    return (x == LastCoord) ? '0 : x + pfc_pkg::CoordW'(1);
  endfunction

  function automatic logic [pfc_pkg::CoordW-1:0] dec(input logic [pfc_pkg::CoordW-1:0] x);
    return (x == '0) ? LastCoord : x - pfc_pkg::CoordW'(1);
  endfunction

  function automatic logic [pfc_pkg::SymW-1:0] cell_idx(input logic [pfc_pkg::CoordW-1:0] r,
                                                        input logic [pfc_pkg::CoordW-1:0] c);
    return pfc_pkg::SymW'(r) * pfc_pkg::SymW'(pfc_pkg::GridSide) + pfc_pkg::SymW'(c);
  endfunction

  logic [pfc_pkg::CoordW-1:0] r1, c1, r2, c2;
  logic [pfc_pkg::CoordW-1:0] or1, oc1, or2, oc2;

  always_comb begin
    r1  = row_of(pos_a_i);
    r2  = row_of(pos_b_i);
    c1  = col_of(pos_a_i, r1);
    c2  = col_of(pos_b_i, r2);
    // rectangle
    or1 = r1;
    oc1 = c2;
    or2 = r2;
    oc2 = c1;
    if (!decrypt_i) begin
      if (r1 == r2) begin
        oc1 = inc(c1);
        oc2 = inc(c2);
      end else if (c1 == c2) begin
        or1 = inc(r1);
        or2 = inc(r2);
        oc1 = c1;
        oc2 = c2;
      end
    end else begin
      if (c1 == c2) begin
        or1 = dec(r1);
        or2 = dec(r2);
        oc1 = c1;
        oc2 = c2;
      end else if (r1 == r2) begin
        oc1 = dec(c1);
        oc2 = dec(c2);
      end
    end
    cell_a_o = cell_idx(or1, oc1);
    cell_b_o = cell_idx(or2, oc2);
  end

endmodule

// ===== design/playfair_6x6_digraph_cipher.sv =====
// digraph request: position lookup, then cell lookup in ADDR (busy), then the registered result strobe
// (two read ports per table of the key square); a new request can be taken in IDLE before the last result is out
// key character and start are handled without leaving IDLE; finish walks all 36 symbols in FILL (busy)
// status-1 digraphs (key not finished) return in the cycle after accept; the receiver cannot stall
// reset clears the used bits, fill count, key ready and mode; square contents undefined
module playfair_6x6_digraph_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  first_char_i,
  input  logic [7:0]  second_char_i,
  output logic        done_o,
  output logic [7:0]  out_first_o,
  output logic [7:0]  out_second_o,
  output logic        status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pfc_pkg::state_e   state_q, state_d;
  pfc_pkg::sq_ctrl_t sq_ctrl;
  pfc_pkg::sq_data_t sq_data;
  pfc_pkg::kind_e    kind;

  logic [pfc_pkg::SymW-1:0] fill_idx_q, fill_idx_d;
  logic                     key_ready_q, key_ready_d;
  logic                     decrypt_q;
  logic                     emit_q, emit_d;
  logic                     valid_q, valid_d;
  logic [7:0]               out_first_q, out_first_d;
  logic [7:0]               out_second_q, out_second_d;
  logic                     status_q, status_d;
  logic                     accept, cfg_wr, fill_last;
  logic [pfc_pkg::SymW-1:0] sym_a, sym_b, rule_a, rule_b;
  pfc_pkg::reg_idx_e        reg_idx;

  assign kind      = pfc_pkg::kind_e'(kind_i);
  assign accept    = start && !busy;
  assign busy      = (state_q != pfc_pkg::ST_IDLE);
  assign fill_last = (fill_idx_q == pfc_pkg::SymW'(pfc_pkg::NumCells - 1));

  // config port
  assign pready  = 1'b1;
  assign reg_idx = pfc_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == pfc_pkg::REG_DECRYPT);
  assign prdata  = (reg_idx == pfc_pkg::REG_DECRYPT) ? {31'b0, decrypt_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q <= 1'b0;
    end else if (cfg_wr) begin
      decrypt_q <= pwdata[0];
    end
  end

  // normalized digraph letters, equal pair fix when enciphering
  always_comb begin
    sym_a = pfc_pkg::to_symbol(first_char_i);
    sym_b = pfc_pkg::to_symbol(second_char_i);
    if (!decrypt_q && sym_a == sym_b) begin
      sym_b = pfc_pkg::FillSymbol;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfc_pkg::ST_IDLE: begin
        if (accept && kind == pfc_pkg::KIND_FINISH) begin
          state_d = pfc_pkg::ST_FILL;
        end else if (accept && kind == pfc_pkg::KIND_DIGRAPH && key_ready_q) begin
          state_d = pfc_pkg::ST_ADDR;
        end
      end
      pfc_pkg::ST_FILL: begin
        if (fill_last) begin
          state_d = pfc_pkg::ST_IDLE;
        end
      end
      pfc_pkg::ST_ADDR: state_d = pfc_pkg::ST_IDLE;
      default:          state_d = pfc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    sq_ctrl            = '0;
    sq_ctrl.sym_a      = sym_a;
    sq_ctrl.sym_b      = sym_b;
    sq_ctrl.cell_a     = rule_a;
    sq_ctrl.cell_b     = rule_b;
    fill_idx_d         = fill_idx_q;
    key_ready_d        = key_ready_q;
    emit_d             = 1'b0;
    valid_d            = emit_q;
    out_first_d        = out_first_q;
    out_second_d       = out_second_q;
    status_d           = status_q;
    if (emit_q) begin
      out_first_d  = pfc_pkg::to_ascii(sq_data.cell_a);
      out_second_d = pfc_pkg::to_ascii(sq_data.cell_b);
      status_d     = 1'b0;
    end
    case (state_q)
      pfc_pkg::ST_IDLE: begin
        if (accept) begin
          case (kind)
            pfc_pkg::KIND_START: begin
              sq_ctrl.clear = 1'b1;
              key_ready_d   = 1'b0;
            end
            pfc_pkg::KIND_KEY: begin
              sq_ctrl.place_en  = !key_ready_q;
              sq_ctrl.place_sym = pfc_pkg::to_symbol(first_char_i);
            end
            pfc_pkg::KIND_FINISH: begin
              fill_idx_d = '0;
            end
            pfc_pkg::KIND_DIGRAPH: begin
              if (key_ready_q) begin
                sq_ctrl.sym_rd_en = 1'b1;
              end else begin
                valid_d      = 1'b1;
                out_first_d  = first_char_i;
                out_second_d = second_char_i;
                status_d     = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      pfc_pkg::ST_FILL: begin
        sq_ctrl.place_en  = 1'b1;
        sq_ctrl.place_sym = fill_idx_q;
        fill_idx_d        = fill_idx_q + pfc_pkg::SymW'(1);
        if (fill_last) begin
          key_ready_d = 1'b1;
        end
      end
      pfc_pkg::ST_ADDR: begin
        sq_ctrl.cell_rd_en = 1'b1;
        emit_d             = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfc_pkg::ST_IDLE;
      fill_idx_q  <= '0;
      key_ready_q <= 1'b0;
      emit_q      <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_idx_q  <= fill_idx_d;
      key_ready_q <= key_ready_d;
      emit_q      <= emit_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
    status_q     <= status_d;
  end

  assign done_o       = valid_q;
  assign out_first_o  = out_first_q;
  assign out_second_o = out_second_q;
  assign status_o     = status_q;

  pfc_square u_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sq_ctrl),
    .data_o (sq_data)
  );

  pfc_rule u_rule (
    .pos_a_i   (sq_data.pos_a),
    .pos_b_i   (sq_data.pos_b),
    .decrypt_i (decrypt_q),
    .cell_a_o  (rule_a),
    .cell_b_o  (rule_b)
  );

  // cell lookup always yields a strobe in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit_q |=> done_o)
    else $error("cipher result lost");

  // a ciphered result needs a finished square
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !status_o) |-> $past(key_ready_q))
    else $error("ciphered result without finished key");

  // fill walk ends with the key ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfc_pkg::ST_FILL && fill_last) |=> (key_ready_q && !busy))
    else $error("fill walk did not finish the key");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int CycleLimit = 600000;
  localparam int SettleCycles = 45;
  localparam int PhaseRequests = 400;
  localparam int MaxReports = 50;
  localparam logic [2:0] DecryptAddr = 3'(4 * pfc_pkg::REG_DECRYPT);
  localparam logic [2:0] SpareAddr = 3'd4;

  typedef struct packed {
    pfc_pkg::kind_e kind;
    logic [7:0]     c1;
    logic [7:0]     c2;
  } request_t;

  typedef struct packed {
    logic [7:0] o1;
    logic [7:0] o2;
    logic       st;
  } digraph_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind_i = pfc_pkg::KIND_START;
  logic [7:0]  first_char_i = 8'h00;
  logic [7:0]  second_char_i = 8'h00;
  logic        done_o;
  logic [7:0]  out_first_o;
  logic [7:0]  out_second_o;
  logic        status_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  playfair_6x6_digraph_cipher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .first_char_i  (first_char_i),
    .second_char_i (second_char_i),
    .done_o        (done_o),
    .out_first_o   (out_first_o),
    .out_second_o  (out_second_o),
    .status_o      (status_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // key square mirror
  logic [5:0] square_cell [pfc_pkg::NumCells];
  logic [5:0] symbol_pos [pfc_pkg::NumCells];
  logic       symbol_placed [pfc_pkg::NumCells];
  int         cells_filled = 0;
  logic       square_ready = 1'b0;
  logic       decipher_mode = 1'b0;

  request_t        pending_requests [$];
  digraph_result_t expected_digraphs [$];
  request_t        cur_req;

  int idle_pct = 0;
  int mismatch_count = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_keyed_checked = 0;
  int n_sessions = 0;
  int n_queued = 0;
  int cycle_count = 0;
  int phase_idle [4] = '{0, 50, 0, 38};
  logic phase_mode [4] = '{1'b1, 1'b0, 1'b1, 1'b0};

  initial begin
    symbol_placed = '{default: 1'b0};
  end

  function automatic logic [5:0] norm_symbol(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      return 6'(c - "a");
    end else if (c >= "0" && c <= "9") begin
      return 6'(c - "0" + 8'(pfc_pkg::NumLetters));
    end
    return pfc_pkg::FillSymbol;
  endfunction

  function automatic logic [7:0] symbol_char(input logic [5:0] s);
    if (s < 6'(pfc_pkg::NumLetters)) begin
      return 8'("a" + s);
    end
    return 8'("0" + (s - 6'(pfc_pkg::NumLetters)));
  endfunction

  function automatic void place_symbol(input logic [5:0] s);
    if (int'(s) >= pfc_pkg::NumCells || symbol_placed[s] ||
        cells_filled >= pfc_pkg::NumCells) begin
      return;
    end
    symbol_placed[s] = 1'b1;
    square_cell[cells_filled] = s;
    symbol_pos[s] = 6'(cells_filled);
    cells_filled++;
  endfunction

  function automatic logic [5:0] cell_at(input int row, input int col);
    return square_cell[(row % pfc_pkg::GridSide) * pfc_pkg::GridSide +
                       (col % pfc_pkg::GridSide)];
  endfunction

  task automatic predict_request(input request_t r);
    logic [5:0] sa, sb, oa, ob;
    int r1, k1, r2, k2;
    digraph_result_t res;
    case (r.kind)
      pfc_pkg::KIND_START: begin
        symbol_placed = '{default: 1'b0};
        cells_filled = 0;
        square_ready = 1'b0;
      end
      pfc_pkg::KIND_KEY: begin
        if (!square_ready) place_symbol(norm_symbol(r.c1));
      end
      pfc_pkg::KIND_FINISH: begin
        for (int i = 0; i < pfc_pkg::NumCells; i++) place_symbol(6'(i));
        square_ready = 1'b1;
      end
      default: begin
        if (!square_ready) begin
          res = '{o1: r.c1, o2: r.c2, st: 1'b1};
        end else begin
          sa = norm_symbol(r.c1);
          sb = norm_symbol(r.c2);
          if (!decipher_mode && sa == sb) sb = pfc_pkg::FillSymbol;
          r1 = symbol_pos[sa] / pfc_pkg::GridSide;
          k1 = symbol_pos[sa] % pfc_pkg::GridSide;
          r2 = symbol_pos[sb] / pfc_pkg::GridSide;
          k2 = symbol_pos[sb] % pfc_pkg::GridSide;
          if (!decipher_mode) begin
            if (r1 == r2) begin
              oa = cell_at(r1, k1 + 1);
              ob = cell_at(r2, k2 + 1);
            end else if (k1 == k2) begin
              oa = cell_at(r1 + 1, k1);
              ob = cell_at(r2 + 1, k2);
            end else begin
              oa = cell_at(r1, k2);
              ob = cell_at(r2, k1);
            end
          end else begin
            if (k1 == k2) begin
              oa = cell_at(r1 + pfc_pkg::GridSide - 1, k1);
              ob = cell_at(r2 + pfc_pkg::GridSide - 1, k2);
            end else if (r1 == r2) begin
              oa = cell_at(r1, k1 + pfc_pkg::GridSide - 1);
              ob = cell_at(r2, k2 + pfc_pkg::GridSide - 1);
            end else begin
              oa = cell_at(r1, k2);
              ob = cell_at(r2, k1);
            end
          end
          res = '{o1: symbol_char(oa), o2: symbol_char(ob), st: 1'b0};
        end
        expected_digraphs.push_back(res);
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxReports) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk_i) begin : drive_requests
    if (rst_ni) begin
      if (start && !busy) begin
        predict_request(cur_req);
        n_accepted++;
      end
      if (!start || !busy) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = pending_requests.pop_front();
          start <= 1'b1;
          kind_i <= cur_req.kind;
          first_char_i <= cur_req.c1;
          second_char_i <= cur_req.c2;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : check_results
    digraph_result_t want;
    if (rst_ni && done_o) begin
      if (expected_digraphs.size() == 0) begin
        report_mismatch($sformatf("result %02h %02h status %0d with no request pending",
                                  out_first_o, out_second_o, status_o));
      end else begin
        want = expected_digraphs.pop_front();
        n_checked++;
        if (!want.st) n_keyed_checked++;
        if (out_first_o !== want.o1) begin
          report_mismatch($sformatf("out_first %02h, expected %02h", out_first_o, want.o1));
        end
        if (out_second_o !== want.o2) begin
          report_mismatch($sformatf("out_second %02h, expected %02h", out_second_o, want.o2));
        end
        if (status_o !== want.st) begin
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.st));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_digraphs.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_request(input pfc_pkg::kind_e k, input logic [7:0] a,
                              input logic [7:0] b);
    request_t r;
    r = '{kind: k, c1: a, c2: b};
    pending_requests.push_back(r);
    n_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || start || busy || expected_digraphs.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (addr == DecryptAddr) decipher_mode = data[0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check_mode();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= DecryptAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (prdata !== {31'd0, decipher_mode}) begin
      report_mismatch($sformatf("decrypt_mode read %08h, expected %0d", prdata, decipher_mode));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(input logic m);
    apb_write(DecryptAddr, ($urandom() & 32'hFFFF_FFFE) | 32'(m));
    apb_check_mode();
  endtask

  function automatic logic [7:0] random_symbol_char();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'("a" + $urandom_range(25));
      4, 5:       return 8'("A" + $urandom_range(25));
      6, 7:       return 8'("0" + $urandom_range(9));
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_session();
    int style, n_key, n_dig;
    logic [7:0] x, y;
    style = $urandom_range(99);
    n_key = ($urandom_range(9) == 0) ? $urandom_range(36, 48) : $urandom_range(0, 12);
    n_dig = $urandom_range(4, 16);
    n_sessions++;
    if (style >= 5) push_request(pfc_pkg::KIND_START, 8'($urandom()), 8'($urandom()));
    for (int i = 0; i < n_key; i++) begin
      push_request(pfc_pkg::KIND_KEY, random_symbol_char(), 8'($urandom()));
    end
    if ($urandom_range(9) == 0) begin
      push_request(pfc_pkg::KIND_DIGRAPH, 8'($urandom()), 8'($urandom()));
    end
    if (style >= 10) push_request(pfc_pkg::KIND_FINISH, 8'($urandom()), 8'($urandom()));
    if ($urandom_range(9) == 0) begin
      push_request(pfc_pkg::KIND_FINISH, 8'($urandom()), 8'($urandom()));
    end
    if ($urandom_range(9) == 0) begin
      push_request(pfc_pkg::KIND_KEY, random_symbol_char(), 8'($urandom()));
    end
    for (int i = 0; i < n_dig; i++) begin
      x = random_symbol_char();
      y = ($urandom_range(6) == 0) ? x : random_symbol_char();
      push_request(pfc_pkg::KIND_DIGRAPH, x, y);
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_check_mode();
    set_mode(1'b0);

    // digraphs ahead of any key pass through
    push_request(pfc_pkg::KIND_DIGRAPH, 8'h00, 8'hFF);
    push_request(pfc_pkg::KIND_DIGRAPH, "A", "z");
    push_request(pfc_pkg::KIND_START, 8'hFF, 8'h00);
    push_request(pfc_pkg::KIND_KEY, "P", 8'hFF);
    push_request(pfc_pkg::KIND_KEY, "l", 8'h00);
    push_request(pfc_pkg::KIND_KEY, "a", 8'h00);
    push_request(pfc_pkg::KIND_KEY, "y", 8'h00);
    push_request(pfc_pkg::KIND_KEY, " ", 8'h00);
    push_request(pfc_pkg::KIND_KEY, "F", 8'h00);
    push_request(pfc_pkg::KIND_KEY, "a", 8'h00);
    push_request(pfc_pkg::KIND_KEY, "9", 8'h00);
    push_request(pfc_pkg::KIND_KEY, 8'hFF, 8'h00);
    push_request(pfc_pkg::KIND_DIGRAPH, "h", "i");
    push_request(pfc_pkg::KIND_FINISH, 8'h00, 8'hFF);
    push_request(pfc_pkg::KIND_FINISH, 8'hFF, 8'hFF);
    push_request(pfc_pkg::KIND_KEY, "q", 8'h00);
    push_request(pfc_pkg::KIND_DIGRAPH, "l", "L");
    push_request(pfc_pkg::KIND_DIGRAPH, "z", "z");
    push_request(pfc_pkg::KIND_DIGRAPH, "p", "l");
    push_request(pfc_pkg::KIND_DIGRAPH, "p", "b");
    push_request(pfc_pkg::KIND_DIGRAPH, "a", "r");
    push_request(pfc_pkg::KIND_DIGRAPH, 8'hFF, "0");
    wait_idle();
    apb_write(SpareAddr, 32'hFFFF_FFFF);
    set_mode(1'b1);
    push_request(pfc_pkg::KIND_DIGRAPH, "l", "l");
    push_request(pfc_pkg::KIND_DIGRAPH, "p", "b");
    push_request(pfc_pkg::KIND_DIGRAPH, "p", "l");
    push_request(pfc_pkg::KIND_DIGRAPH, "9", "Z");
    push_request(pfc_pkg::KIND_DIGRAPH, 8'h00, 8'h7F);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      set_mode(phase_mode[p]);
      idle_pct = phase_idle[p];
      n_queued = 0;
      while (n_queued < PhaseRequests) queue_session();
    end

    wait_idle();
    $display("%0d requests in %0d random key sessions, %0d digraph results checked",
             n_accepted, n_sessions, n_checked);
    $display("%0d of them against a finished square, both cipher directions, sender idle 0-50%%",
             n_keyed_checked);
    if (mismatch_count == 0 && expected_digraphs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
